// ----- hw/rtl/prime_trial_division_test_unit_defines.svh -----
// assertion macros shared by the prime trial division rtl
`ifndef PRIME_TRIAL_DIVISION_TEST_UNIT_DEFINES_SVH
`define PRIME_TRIAL_DIVISION_TEST_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define PTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ptd_pkg.sv -----
// shared constants and types of the prime trial division unit
package ptd_pkg;

	// default width of the tested value
	localparam int unsigned VALUE_BITS_DEF = 31;

	// status of the serial divider as seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} ptd_div_stat_t;

endpackage

// ----- hw/rtl/prime_trial_division_test_unit.sv -----
// Primality test by trial division over divisors 3, 5, 7, 11, 13, ... (6k-1 and 6k+1).
// One request in gives one result out: prime_or_zero echoes the value if it is prime,
// zero otherwise, and is_prime carries the flag on m_tuser. Values below 2, the value 3
// and even values are settled in the classify state; other values go through a
// bit-serial divider, starting with the divisor 3, that also gives the quotient used for
// the stop test (divisor > value / divisor). One item is worked on at a time; a finished
// result waits in the output register while the next request is taken.
`include "prime_trial_division_test_unit_defines.svh"

module prime_trial_division_test_unit #(
	parameter int unsigned VALUE_BITS = ptd_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,  // candidate, zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((VALUE_BITS+7)/8)*8-1:0]     m_tdata,  // prime_or_zero, zero pad
	output logic                                m_tuser   // is_prime
);
	import ptd_pkg::*;

	localparam int unsigned DataW = ((VALUE_BITS + 7) / 8) * 8;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLASS = 4'b0010,
		S_DIV   = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] d_q, d_d;
	logic                  step_q, step_d;
	logic                  prime_q, prime_d;
	logic                  div_start;
	logic                  load_out;
	logic                  m_tvalid_q;
	logic [VALUE_BITS-1:0] res_q;
	logic                  res_prime_q;
	logic [VALUE_BITS-1:0] quot;
	logic [VALUE_BITS-1:0] rem;
	ptd_div_stat_t         div_stat;

	assign s_tready = (state_q == S_IDLE);

	// sequencer: classify, then walk the divisor sequence
	always_comb begin
		state_d   = state_q;
		d_d       = d_q;
		step_d    = step_q;
		prime_d   = prime_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_CLASS;
				end
			end
			S_CLASS: begin
				if (n_q < VALUE_BITS'(2)) begin
					prime_d = 1'b0;
					state_d = S_DONE;
				end else if (n_q == VALUE_BITS'(2) || n_q == VALUE_BITS'(3)) begin
					prime_d = 1'b1;
					state_d = S_DONE;
				end else if (!n_q[0]) begin
					prime_d = 1'b0;
					state_d = S_DONE;
				end else begin
					d_d       = VALUE_BITS'(3);
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					if (d_q == VALUE_BITS'(3)) begin
						// multiple of three check, then start the wheel at five
						if (rem == '0) begin
							prime_d = 1'b0;
							state_d = S_DONE;
						end else begin
							d_d       = VALUE_BITS'(5);
							step_d    = 1'b0;
							div_start = 1'b1;
						end
					end else if (quot < d_q) begin
						prime_d = 1'b1;
						state_d = S_DONE;
					end else if (rem == '0) begin
						prime_d = 1'b0;
						state_d = S_DONE;
					end else begin
						// steps alternate between 2 and 4
						d_d       = d_q + (step_q ? VALUE_BITS'(4) : VALUE_BITS'(2));
						step_d    = ~step_q;
						div_start = 1'b1;
					end
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			n_q <= s_tdata[VALUE_BITS-1:0];
		end
		d_q     <= d_d;
		step_q  <= step_d;
		prime_q <= prime_d;
		if (load_out) begin
			res_q       <= prime_q ? n_q : '0;
			res_prime_q <= prime_q;
		end
	end

	// shared serial divider
	ptd_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_d),
		.quot     (quot),
		.rem      (rem),
		.stat     (div_stat)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DataW'(res_q);
	assign m_tuser  = res_prime_q;

	// checks
	`PTD_ASSERT_IMP(a_done_in_div, clk, arst_n, div_stat.done, state_q == S_DIV, "divider done outside trial state")
	`PTD_ASSERT_IMP(a_zero_if_composite, clk, arst_n, m_tvalid_q && !res_prime_q, res_q == '0, "nonzero value for a composite")
	`PTD_ASSERT_IMP(a_prime_odd_or_two, clk, arst_n, m_tvalid_q && res_prime_q, res_q[0] || res_q == VALUE_BITS'(2), "even value flagged prime")

endmodule

// ----- hw/rtl/ptd_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
`include "prime_trial_division_test_unit_defines.svh"

module ptd_div #(
	parameter int unsigned VALUE_BITS = ptd_pkg::VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_BITS-1:0]   dividend,
	input  logic [VALUE_BITS-1:0]   divisor,
	output logic [VALUE_BITS-1:0]   quot,
	output logic [VALUE_BITS-1:0]   rem,
	output ptd_pkg::ptd_div_stat_t  stat
);
	import ptd_pkg::*;

	localparam int unsigned CntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(VALUE_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CntW-1:0]       cnt_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [VALUE_BITS-1:0] dvs_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;

	// shift the next dividend bit into the partial remainder and try the subtract
	assign trial = {rem_q, dvd_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntLast) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend register turns into the quotient as bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[VALUE_BITS]) begin
				rem_q <= diff[VALUE_BITS-1:0];
				dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[VALUE_BITS-1:0];
				dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot      = dvd_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// checks
	`PTD_ASSERT_IMP(a_no_restart, clk, arst_n, start, !busy_q, "divider started while busy")
	`PTD_ASSERT_NXT(a_done_after_last, clk, arst_n, busy_q && !start && cnt_q == CntLast, done_q, "no done after last step")
	`PTD_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q, "done while still busy")

endmodule

// ----- tb/prime_trial_division_test_unit_tb.sv -----
// self-checking testbench of the prime trial division unit
`timescale 1ns / 1ps

module prime_trial_division_test_unit_tb;

	localparam int unsigned VB          = ptd_pkg::VALUE_BITS_DEF;
	localparam int unsigned TDATA_W     = ((VB + 7) / 8) * 8;
	localparam int unsigned QUIET_LIMIT = 2000000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned TAIL_CYCLES = 200;

	typedef struct {
		logic [VB-1:0] candidate;
		logic [VB-1:0] prime_or_zero;
		logic          is_prime;
	} prime_verdict_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;

	prime_verdict_t verdict_q[$];
	prime_verdict_t want;
	int unsigned    error_cnt   = 0;
	int unsigned    quiet_cnt   = 0;
	bit             tx_idle_on  = 1'b1;
	bit             rx_idle_on  = 1'b1;
	bit             rx_hold_req = 1'b0;
	int unsigned    hold_left   = 0;
	int unsigned    stall_left  = 0;

	prime_trial_division_test_unit #(
		.VALUE_BITS(VB)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// trial division over 6k-1 / 6k+1 divisors
	function automatic bit primality_of(input logic [VB-1:0] value);
		longint unsigned n;
		longint unsigned d;
		longint unsigned step;
		n = 64'(value);
		if (n < 2)
			return 1'b0;
		if (n == 2 || n == 3)
			return 1'b1;
		if (n % 2 == 0 || n % 3 == 0)
			return 1'b0;
		d    = 5;
		step = 2;
		while (d <= n / d) begin
			if (n % d == 0)
				return 1'b0;
			d    = d + step;
			step = 6 - step;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_cnt++;
	endtask

	// offer one request, optionally with the pad bits above the value set
	task automatic send_candidate(input longint unsigned value, input bit pad = 1'b0);
		prime_verdict_t v;
		int unsigned    gap;
		v.candidate     = value[VB-1:0];
		v.is_prime      = primality_of(v.candidate);
		v.prime_or_zero = v.is_prime ? v.candidate : '0;
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W - VB){pad}}, v.candidate};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		verdict_q.push_back(v);
	endtask

	// stop offering and wait for every pending result
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// extremes, small primes and squares, wheel steps, stray pad bits
	task automatic test_edges();
		longint unsigned picks[] = '{
			0, 1, 2, 3, 4, 5, 9, 25, 35, 49, 121, 169, 97, 7919, 65537,
			1000003, 32'h2AAAAAAA, 32'h55555555, 2147483643, 2147483645,
			2147483646, 2147483647
		};
		foreach (picks[i])
			send_candidate(picks[i]);
		// pad bits must be ignored
		send_candidate(7, 1'b1);
		send_candidate(8, 1'b1);
		drain_results();
	endtask

	// receiver holds off while quick requests keep coming
	task automatic test_backpressure();
		longint unsigned quick[] = '{
			0, 1, 2, 3, 4, 6, 9, 10, 25, 2147483646, 1073741826, 5, 12, 15
		};
		tx_idle_on  = 1'b0;
		@(posedge clk);
		rx_hold_req = 1'b1;
		foreach (quick[i])
			send_candidate(quick[i]);
		drain_results();
		tx_idle_on = 1'b1;
	endtask

	// mostly small values; large values carry a small factor to stay quick
	task automatic test_random();
		longint unsigned small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
		longint unsigned p;
		longint unsigned k;
		longint unsigned value;
		int unsigned     kind;
		for (int i = 0; i < 64; i++) begin
			tx_idle_on = (i < 44);
			rx_idle_on = (i < 44);
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				value = 64'($urandom_range(0, 5000));
			end else if (kind < 8) begin
				value = 64'($urandom_range(5001, 1 << 20));
			end else begin
				p     = small_primes[$urandom_range(0, small_primes.size() - 1)];
				k     = 64'($urandom_range(1, 32'(64'h7FFFFFFF / p)));
				value = p * k;
			end
			send_candidate(value);
		end
		drain_results();
	endtask

	// receiver side: long hold on request, short random stalls otherwise
	always @(negedge clk) begin
		if (rx_hold_req) begin
			hold_left   = HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each accepted result with the oldest pending verdict
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", m_tdata[VB-1:0]));
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[VB-1:0] !== want.prime_or_zero)
					report_mismatch($sformatf("prime_or_zero for %0d: got %0d, expected %0d",
						want.candidate, m_tdata[VB-1:0], want.prime_or_zero));
				if (m_tuser !== want.is_prime)
					report_mismatch($sformatf("is_prime for %0d: got %0b, expected %0b",
						want.candidate, m_tuser, want.is_prime));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cnt = 0;
			else
				quiet_cnt++;
			if (quiet_cnt >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// reset, tests in turn, final verdict
	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_edges();
		test_backpressure();
		test_random();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
